@@ sv/btc_pkg.sv @@
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants for the barometer temperature compensation unit.
// ----------------------------------------------------------------------------
package btc_pkg;

	localparam int CAL_W   = 16;
	localparam int RAW_W   = 24;
	localparam int TEMP_W  = 20;
	localparam int PRES_W  = 32;
	localparam int BAND_W  = 2;
	localparam int INDEX_W = 3;

	// register indexes on the configuration port
	localparam logic [INDEX_W-1:0] REG_PRESSURE_SENSITIVITY  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_PRESSURE_OFFSET       = 3'd1;
	localparam logic [INDEX_W-1:0] REG_SENSITIVITY_TEMP_COEF = 3'd2;
	localparam logic [INDEX_W-1:0] REG_OFFSET_TEMP_COEF      = 3'd3;
	localparam logic [INDEX_W-1:0] REG_REFERENCE_TEMPERATURE = 3'd4;
	localparam logic [INDEX_W-1:0] REG_TEMP_SENSITIVITY      = 3'd5;

	// correction band codes
	localparam logic [BAND_W-1:0] BAND_NONE      = 2'd0;
	localparam logic [BAND_W-1:0] BAND_COLD      = 2'd1;
	localparam logic [BAND_W-1:0] BAND_VERY_COLD = 2'd2;

	typedef struct packed {
		logic [CAL_W-1:0] pressure_sensitivity;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sensitivity_temp_coef;
		logic [CAL_W-1:0] offset_temp_coef;
		logic [CAL_W-1:0] reference_temperature;
		logic [CAL_W-1:0] temp_sensitivity;
	} cal_t;

endpackage

@@ sv/btc_core.sv @@
// ----------------------------------------------------------------------------
// btc_core
// Nine-stage compensation datapath with a common advance enable.
// ----------------------------------------------------------------------------
module btc_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [btc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [btc_pkg::RAW_W-1:0]           raw_temperature,
	input  btc_pkg::cal_t                       cal,
	output logic                                out_valid,
	output logic signed [btc_pkg::TEMP_W-1:0]   temperature,
	output logic signed [btc_pkg::PRES_W-1:0]   pressure,
	output logic [btc_pkg::BAND_W-1:0]          correction_band
);

	logic [9:1] v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[8:1], in_valid};
		end
	end

	assign out_valid = v_q[9];

	// stage 1: dT
	logic signed [24:0] dt_c;
	logic signed [24:0] dt_s1;
	logic [23:0]        d1_s1;

	assign dt_c = $signed({1'b0, raw_temperature}) -
	              $signed({1'b0, cal.reference_temperature, 8'h00});

	// stage 2: products on dT
	logic signed [41:0] tprod_c, offp_c, sensp_c;
	logic signed [49:0] dtsq_c;
	logic signed [41:0] tprod_s2, offp_s2, sensp_s2;
	logic [48:0]        dtsq_s2;
	logic [23:0]        d1_s2;

	assign tprod_c = dt_s1 * $signed({1'b0, cal.temp_sensitivity});
	assign offp_c  = dt_s1 * $signed({1'b0, cal.offset_temp_coef});
	assign sensp_c = dt_s1 * $signed({1'b0, cal.sensitivity_temp_coef});
	assign dtsq_c  = dt_s1 * dt_s1;

	// stage 3: TEMP, OFF, SENS, T2 and band; a = TEMP-2000, b = TEMP+1500
	logic signed [41:0] tsh_c, offsh_c, sensh_c;
	logic signed [19:0] a_c;
	logic [1:0]         band_c;
	logic signed [19:0] temp_s3, a_s3, b_s3;
	logic signed [41:0] off_s3, sens_s3;
	logic [17:0]        t2_s3;
	logic [1:0]         band_s3;
	logic [23:0]        d1_s3;

	assign tsh_c   = tprod_s2 >>> 23;
	assign offsh_c = offp_s2 >>> 7;
	assign sensh_c = sensp_s2 >>> 8;
	assign a_c     = tsh_c[19:0];

	always_comb begin
		priority if (a_c < -20'sd3500) begin
			band_c = btc_pkg::BAND_VERY_COLD;
		end else if (a_c < 20'sd0) begin
			band_c = btc_pkg::BAND_COLD;
		end else begin
			band_c = btc_pkg::BAND_NONE;
		end
	end

	// stage 4: squares
	logic signed [39:0] asq_c, bsq_c;
	logic [35:0]        asq_s4, bsq_s4;
	logic signed [19:0] temp_s4;
	logic signed [41:0] off_s4, sens_s4;
	logic [17:0]        t2_s4;
	logic [1:0]         band_s4;
	logic [23:0]        d1_s4;

	assign asq_c = a_s3 * a_s3;
	assign bsq_c = b_s3 * b_s3;

	// stage 5: OFF2, SENS2, final temperature
	logic [38:0]        fa_c, sb7_c;
	logic [39:0]        sb11_c;
	logic [39:0]        off2_c, sens2_c;
	logic [17:0]        t2_eff_c;
	logic               cold_c, vcold_c;
	logic signed [19:0] tout_s5;
	logic signed [41:0] off_s5, sens_s5;
	logic [39:0]        off2_s5, sens2_s5;
	logic [1:0]         band_s5;
	logic [23:0]        d1_s5;

	assign cold_c   = (band_s4 != btc_pkg::BAND_NONE);
	assign vcold_c  = (band_s4 == btc_pkg::BAND_VERY_COLD);
	assign fa_c     = {1'b0, asq_s4, 2'b00} + {3'b000, asq_s4};
	assign sb7_c    = {bsq_s4, 3'b000} - {3'b000, bsq_s4};
	assign sb11_c   = {1'b0, bsq_s4, 3'b000} + {3'b000, bsq_s4, 1'b0} + {4'b0000, bsq_s4};
	assign t2_eff_c = cold_c ? t2_s4 : 18'd0;

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (cold_c) begin
			off2_c  = {2'b00, fa_c[38:1]};
			sens2_c = {3'b000, fa_c[38:2]};
		end
		if (vcold_c) begin
			off2_c  = off2_c + {1'b0, sb7_c};
			sens2_c = sens2_c + {1'b0, sb11_c[39:1]};
		end
	end

	// stage 6: corrected OFF and SENS
	logic signed [41:0] offa_s6, sensa_s6;
	logic signed [19:0] tout_s6;
	logic [1:0]         band_s6;
	logic [23:0]        d1_s6;

	// stage 7: D1*SENS as two partial products
	logic [43:0]        pl_c;
	logic signed [46:0] ph_c;
	logic [43:0]        pl_s7;
	logic signed [46:0] ph_s7;
	logic signed [41:0] offa_s7;
	logic signed [19:0] tout_s7;
	logic [1:0]         band_s7;

	assign pl_c = {20'd0, d1_s6} * {24'd0, sensa_s6[19:0]};
	assign ph_c = $signed({1'b0, d1_s6}) * $signed(sensa_s6[41:20]);

	// stage 8: partial product sum
	logic signed [67:0] prod_c;
	logic signed [67:0] prod_s8;
	logic signed [41:0] offa_s8;
	logic signed [19:0] tout_s8;
	logic [1:0]         band_s8;

	assign prod_c = $signed({ph_s7[46], ph_s7, 20'd0}) + $signed({24'd0, pl_s7});

	// stage 9: subtract offset, scale and saturate
	logic signed [67:0] diff_c, p_c;
	logic signed [31:0] psat_c;
	logic signed [31:0] pres_s9;
	logic signed [19:0] tout_s9;
	logic [1:0]         band_s9;

	assign diff_c = (prod_s8 >>> 21) - $signed({{26{offa_s8[41]}}, offa_s8});
	assign p_c    = diff_c >>> 15;

	always_comb begin
		priority if (!p_c[67] && (|p_c[66:31])) begin
			psat_c = 32'sh7FFF_FFFF;
		end else if (p_c[67] && !(&p_c[66:31])) begin
			psat_c = 32'sh8000_0000;
		end else begin
			psat_c = p_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dt_s1    <= dt_c;
			d1_s1    <= raw_pressure;

			tprod_s2 <= tprod_c;
			offp_s2  <= offp_c;
			sensp_s2 <= sensp_c;
			dtsq_s2  <= dtsq_c[48:0];
			d1_s2    <= d1_s1;

			temp_s3  <= a_c + 20'sd2000;
			a_s3     <= a_c;
			b_s3     <= a_c + 20'sd3500;
			off_s3   <= $signed({10'd0, cal.pressure_offset, 16'd0}) + offsh_c;
			sens_s3  <= $signed({11'd0, cal.pressure_sensitivity, 15'd0}) + sensh_c;
			t2_s3    <= dtsq_s2[48:31];
			band_s3  <= band_c;
			d1_s3    <= d1_s2;

			asq_s4   <= asq_c[35:0];
			bsq_s4   <= bsq_c[35:0];
			temp_s4  <= temp_s3;
			off_s4   <= off_s3;
			sens_s4  <= sens_s3;
			t2_s4    <= t2_s3;
			band_s4  <= band_s3;
			d1_s4    <= d1_s3;

			tout_s5  <= temp_s4 - $signed({2'b00, t2_eff_c});
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			band_s5  <= band_s4;
			d1_s5    <= d1_s4;

			offa_s6  <= off_s5 - $signed({2'b00, off2_s5});
			sensa_s6 <= sens_s5 - $signed({2'b00, sens2_s5});
			tout_s6  <= tout_s5;
			band_s6  <= band_s5;
			d1_s6    <= d1_s5;

			pl_s7    <= pl_c;
			ph_s7    <= ph_c;
			offa_s7  <= offa_s6;
			tout_s7  <= tout_s6;
			band_s7  <= band_s6;

			prod_s8  <= prod_c;
			offa_s8  <= offa_s7;
			tout_s8  <= tout_s7;
			band_s8  <= band_s7;

			pres_s9  <= psat_c;
			tout_s9  <= tout_s8;
			band_s9  <= band_s8;
		end
	end

	assign temperature     = tout_s9;
	assign pressure        = pres_s9;
	assign correction_band = band_s9;

endmodule

@@ sv/barometer_temperature_compensation_unit.sv @@
// Throughput: one transaction per cycle; all nine stages advance together and
// hold while the output register is full and m_tready is low.
// Reset: clears the stage valid bits and all six calibration registers to 0.
// ----------------------------------------------------------------------------
// barometer_temperature_compensation_unit
// Second-order pressure/temperature compensation of raw converter readings.
// ----------------------------------------------------------------------------
module barometer_temperature_compensation_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [47:0]                       s_tdata,  // raw_pressure, raw_temperature
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [55:0]                       m_tdata,  // temperature, pressure, correction_band
	input  logic                              cfg_we,
	input  logic [btc_pkg::INDEX_W-1:0]       cfg_index,
	input  logic [btc_pkg::CAL_W-1:0]         cfg_data
);

	btc_pkg::cal_t cal_q;
	logic          en;

	logic signed [btc_pkg::TEMP_W-1:0] temperature;
	logic signed [btc_pkg::PRES_W-1:0] pressure;
	logic [btc_pkg::BAND_W-1:0]        correction_band;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				btc_pkg::REG_PRESSURE_SENSITIVITY:  cal_q.pressure_sensitivity  <= cfg_data;
				btc_pkg::REG_PRESSURE_OFFSET:       cal_q.pressure_offset       <= cfg_data;
				btc_pkg::REG_SENSITIVITY_TEMP_COEF: cal_q.sensitivity_temp_coef <= cfg_data;
				btc_pkg::REG_OFFSET_TEMP_COEF:      cal_q.offset_temp_coef      <= cfg_data;
				btc_pkg::REG_REFERENCE_TEMPERATURE: cal_q.reference_temperature <= cfg_data;
				btc_pkg::REG_TEMP_SENSITIVITY:      cal_q.temp_sensitivity      <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the output register is free or being drained
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	btc_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (s_tvalid),
		.raw_pressure    (s_tdata[23:0]),
		.raw_temperature (s_tdata[47:24]),
		.cal             (cal_q),
		.out_valid       (m_tvalid),
		.temperature     (temperature),
		.pressure        (pressure),
		.correction_band (correction_band)
	);

	assign m_tdata = {2'b00, correction_band, pressure, temperature};

endmodule

@@ sv/btc_checker.sv @@
// ----------------------------------------------------------------------------
// btc_checker
// Port-level checks on the compensation unit, bound to the top level.
// ----------------------------------------------------------------------------
module btc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	logic signed [19:0] temp_w;
	logic [1:0]         band_w;

	assign temp_w = m_tdata[19:0];
	assign band_w = m_tdata[53:52];

	// no result shows while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("m_tvalid high during reset");

	// an empty output register never blocks the input side
	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// stalled result holds its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// band and temperature agree
	a_band_warm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && band_w == btc_pkg::BAND_NONE |-> temp_w >= 20'sd2000)
		else $error("no correction below 20 degC");

	a_band_very_cold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && band_w == btc_pkg::BAND_VERY_COLD |-> temp_w < -20'sd1500)
		else $error("very cold band above -15 degC");

endmodule

bind barometer_temperature_compensation_unit btc_checker u_btc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks barometer_temperature_compensation_unit against an in-bench
// second-order compensation predictor. A directed table of readings and
// calibration writes comes first, followed by random phases with new
// calibration sets and random valid/ready gaps on both stream sides (none in phase 3).
// ----------------------------------------------------------------------------
module tb_top;

	localparam int    CAL_W   = btc_pkg::CAL_W;
	localparam int    RAW_W   = btc_pkg::RAW_W;
	localparam int    TEMP_W  = btc_pkg::TEMP_W;
	localparam int    PRES_W  = btc_pkg::PRES_W;
	localparam int    BAND_W  = btc_pkg::BAND_W;
	localparam int    INDEX_W = btc_pkg::INDEX_W;

	localparam int    CLK_HALF     = 6;
	localparam int    RESET_CYCLES = 9;
	localparam int    PIPE_LATENCY = 9;
	localparam int    IDLE_PCT     = 6;
	localparam int    NUM_PHASES   = 8;
	localparam int    PHASE_ITEMS  = 138;
	localparam int    CYCLE_LIMIT  = 200000;
	localparam int    MAX_REPORTS  = 10;
	localparam longint TEMP_REF       = 2000;
	localparam longint TEMP_VERY_COLD = -1500;
	localparam longint P_MAX = 64'sd2147483647;
	localparam longint P_MIN = -64'sd2147483648;

	// indexes past the last calibration word; the block ignores them
	localparam logic [INDEX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [INDEX_W-1:0] REG_SPARE_B = 3'd7;

	localparam btc_pkg::cal_t TYPICAL_CAL = '{16'd40127, 16'd36924, 16'd23317,
		16'd23282, 16'd33464, 16'd28312};

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic signed [PRES_W-1:0] pressure;
		logic [BAND_W-1:0]        band;
	} reading_t;

	typedef struct {
		bit                 is_write;
		logic [INDEX_W-1:0] index;
		logic [CAL_W-1:0]   value;
		logic [RAW_W-1:0]   raw_p;
		logic [RAW_W-1:0]   raw_t;
		bit                 typed;
		reading_t           want;
	} stim_row_t;

	localparam reading_t RESET_READING = '{20'sd2000, 32'sd0, btc_pkg::BAND_NONE};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [47:0]          s_tdata = '0;  // raw_pressure, raw_temperature
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [55:0]          m_tdata;       // temperature, pressure, correction_band
	logic                 cfg_we = 1'b0;
	logic [INDEX_W-1:0]   cfg_index = '0;
	logic [CAL_W-1:0]     cfg_data = '0;

	btc_pkg::cal_t cal_shadow = '0;
	reading_t   expected_readings[$];
	stim_row_t  directed_rows[$];
	bit         no_idle = 1'b0;
	int         error_count = 0;
	int         reported = 0;
	int         cycle_count = 0;

	barometer_temperature_compensation_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
			input logic [RAW_W-1:0] d2_raw, input btc_pkg::cal_t c);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, t, off, sens, t2, off2, sens2, a, b, p;
		reading_t r;
		d1 = d1_raw;
		d2 = d2_raw;
		c1 = c.pressure_sensitivity;
		c2 = c.pressure_offset;
		c3 = c.sensitivity_temp_coef;
		c4 = c.offset_temp_coef;
		c5 = c.reference_temperature;
		c6 = c.temp_sensitivity;
		// arithmetic shifts on signed 64-bit values floor the quotient
		dt = d2 - (c5 <<< 8);
		t = TEMP_REF + ((dt * c6) >>> 23);
		off = (c2 <<< 16) + ((c4 * dt) >>> 7);
		sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		r.band = btc_pkg::BAND_NONE;
		if (t < TEMP_REF) begin
			a = t - TEMP_REF;
			r.band = btc_pkg::BAND_COLD;
			t2 = (dt * dt) >>> 31;
			off2 = (5 * a * a) >>> 1;
			sens2 = (5 * a * a) >>> 2;
			if (t < TEMP_VERY_COLD) begin
				b = t - TEMP_VERY_COLD;
				r.band = btc_pkg::BAND_VERY_COLD;
				off2 += 7 * b * b;
				sens2 += (11 * b * b) >>> 1;
			end
		end
		p = (((d1 * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
		if (p > P_MAX)
			p = P_MAX;
		if (p < P_MIN)
			p = P_MIN;
		r.temperature = TEMP_W'(t - t2);
		r.pressure = PRES_W'(p);
		return r;
	endfunction

	function automatic btc_pkg::cal_t pick_cal(input int phase);
		logic [CAL_W-1:0] w [6];
		btc_pkg::cal_t c;
		for (int i = 0; i < 6; i++) begin
			case ($urandom_range(3))
				0: w[i] = '0;
				1: w[i] = '1;
				default: w[i] = CAL_W'($urandom);
			endcase
		end
		c = {w[0], w[1], w[2], w[3], w[4], w[5]};
		if (phase == 0)
			c = TYPICAL_CAL;
		else if (phase == 1)
			c = '1;
		else if (phase == 2)
			c = '0;
		return c;
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw_pressure();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// mostly near the reference reading, so all three bands get hit
	function automatic logic [RAW_W-1:0] pick_raw_temp(input logic [CAL_W-1:0] c5);
		longint center, span, v;
		center = longint'(c5) <<< 8;
		span = longint'(1) <<< $urandom_range(24, 2);
		v = center - span + longint'($urandom_range(32'(2 * span)));
		if (v < 0)
			v = 0;
		if (v > 64'hFF_FFFF)
			v = 64'hFF_FFFF;
		case ($urandom_range(7))
			0: return RAW_W'($urandom);
			1: return $urandom_range(1) ? '1 : '0;
			default: return RAW_W'(v);
		endcase
	endfunction

	task automatic add_item(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt);
		directed_rows.push_back('{1'b0, '0, '0, rp, rt, 1'b0, '0});
	endtask

	task automatic add_item_typed(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt,
			input reading_t want);
		directed_rows.push_back('{1'b0, '0, '0, rp, rt, 1'b1, want});
	endtask

	task automatic add_write(input logic [INDEX_W-1:0] idx, input logic [CAL_W-1:0] val);
		directed_rows.push_back('{1'b1, idx, val, '0, '0, 1'b0, '0});
	endtask

	// stop sending and wait until every result is back, then let the pipe settle
	task automatic drain(input int settle);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CAL_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			btc_pkg::REG_PRESSURE_SENSITIVITY:  cal_shadow.pressure_sensitivity = val;
			btc_pkg::REG_PRESSURE_OFFSET:       cal_shadow.pressure_offset = val;
			btc_pkg::REG_SENSITIVITY_TEMP_COEF: cal_shadow.sensitivity_temp_coef = val;
			btc_pkg::REG_OFFSET_TEMP_COEF:      cal_shadow.offset_temp_coef = val;
			btc_pkg::REG_REFERENCE_TEMPERATURE: cal_shadow.reference_temperature = val;
			btc_pkg::REG_TEMP_SENSITIVITY:      cal_shadow.temp_sensitivity = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_cal(input btc_pkg::cal_t c);
		write_reg(btc_pkg::REG_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
		write_reg(btc_pkg::REG_PRESSURE_OFFSET, c.pressure_offset);
		write_reg(btc_pkg::REG_SENSITIVITY_TEMP_COEF, c.sensitivity_temp_coef);
		write_reg(btc_pkg::REG_OFFSET_TEMP_COEF, c.offset_temp_coef);
		write_reg(btc_pkg::REG_REFERENCE_TEMPERATURE, c.reference_temperature);
		write_reg(btc_pkg::REG_TEMP_SENSITIVITY, c.temp_sensitivity);
	endtask

	task automatic send_reading(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt,
			input bit typed, input reading_t want);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rt, rp};
		do
			@(posedge clk);
		while (!s_tready);
		expected_readings.push_back(typed ? want : compensate(rp, rt, cal_shadow));
	endtask

	always @(negedge clk)
		m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin : check_results
		reading_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.temperature = m_tdata[TEMP_W-1:0];
			got.pressure = m_tdata[TEMP_W +: PRES_W];
			got.band = m_tdata[TEMP_W+PRES_W +: BAND_W];
			if (expected_readings.size() == 0) begin
				error_count++;
				if (reported < MAX_REPORTS) begin
					reported++;
					$display("unexpected result transaction: temp %0d pres %0d band %0d",
						got.temperature, got.pressure, got.band);
				end
			end else begin
				want = expected_readings.pop_front();
				if (got.temperature !== want.temperature || got.pressure !== want.pressure
						|| got.band !== want.band) begin
					error_count++;
					if (reported < MAX_REPORTS) begin
						reported++;
						$display("mismatch exp/got: temp %0d/%0d pres %0d/%0d band %0d/%0d",
							want.temperature, got.temperature, want.pressure, got.pressure,
							want.band, got.band);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		// falling edge at time zero so the asynchronous reset takes hold at once
		arst_n <= 1'b0;
		// calibration still at reset: every reading gives 20.00 degC and 0 Pa
		add_item_typed(24'h00_0000, 24'h00_0000, RESET_READING);
		add_item_typed(24'hFF_FFFF, 24'hFF_FFFF, RESET_READING);
		add_item_typed(24'hFF_FFFF, 24'h00_0000, RESET_READING);
		add_write(btc_pkg::REG_PRESSURE_SENSITIVITY, TYPICAL_CAL.pressure_sensitivity);
		add_write(btc_pkg::REG_PRESSURE_OFFSET, TYPICAL_CAL.pressure_offset);
		add_write(btc_pkg::REG_SENSITIVITY_TEMP_COEF, TYPICAL_CAL.sensitivity_temp_coef);
		add_write(btc_pkg::REG_OFFSET_TEMP_COEF, TYPICAL_CAL.offset_temp_coef);
		add_write(btc_pkg::REG_REFERENCE_TEMPERATURE, TYPICAL_CAL.reference_temperature);
		add_write(btc_pkg::REG_TEMP_SENSITIVITY, TYPICAL_CAL.temp_sensitivity);
		add_item(24'd9085466, 24'd8569150);
		// dT = 0 gives exactly 20.00 degC, dT = -1 just below it
		add_item(24'd9085466, 24'd8566784);
		add_item(24'd9085466, 24'd8566783);
		add_item(24'd9085466, 24'd7000000);
		add_item(24'd0, 24'd8000000);
		add_item(24'hFF_FFFF, 24'hFF_FFFF);
		add_item(24'hFF_FFFF, 24'h00_0000);
		// with this slope TEMP = 2000 + dT/256: edges at -15.00 / -15.01 degC
		add_write(btc_pkg::REG_TEMP_SENSITIVITY, 16'd32768);
		add_item(24'd8000000, 24'd7670784);
		add_item(24'd8000000, 24'd7670783);
		// writes past the last register must leave calibration alone
		add_write(REG_SPARE_A, 16'hFFFF);
		add_write(REG_SPARE_B, 16'h1234);
		add_item(24'd5000000, 24'd8400000);
		add_write(btc_pkg::REG_PRESSURE_SENSITIVITY, 16'hFFFF);
		add_write(btc_pkg::REG_PRESSURE_OFFSET, 16'hFFFF);
		add_write(btc_pkg::REG_SENSITIVITY_TEMP_COEF, 16'hFFFF);
		add_write(btc_pkg::REG_OFFSET_TEMP_COEF, 16'hFFFF);
		add_write(btc_pkg::REG_REFERENCE_TEMPERATURE, 16'hFFFF);
		add_write(btc_pkg::REG_TEMP_SENSITIVITY, 16'hFFFF);
		add_item(24'hFF_FFFF, 24'h00_0000);
		add_item(24'h00_0000, 24'hFF_FFFF);
		add_item(24'hFF_FFFF, 24'hFF_FFFF);
		add_item(24'h00_0000, 24'h00_0000);
		add_item(24'hFF_FFFF, 24'hFF_FF00);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				drain(PIPE_LATENCY + 2);
				write_reg(directed_rows[i].index, directed_rows[i].value);
			end else begin
				send_reading(directed_rows[i].raw_p, directed_rows[i].raw_t,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain(PIPE_LATENCY + 2);
			no_idle = (ph == 3);
			load_cal(pick_cal(ph));
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CAL_W'($urandom));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 4 && n == PHASE_ITEMS / 2)
					drain(0);
				send_reading(pick_raw_pressure(),
					pick_raw_temp(cal_shadow.reference_temperature), 1'b0, '0);
			end
		end
		no_idle = 1'b0;

		drain(PIPE_LATENCY + 4);
		if (error_count == 0 && expected_readings.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
sv/btc_pkg.sv
sv/btc_core.sv
sv/barometer_temperature_compensation_unit.sv
sv/btc_checker.sv
test/tb_top.sv
